// ===== src/mlr_pkg.sv =====
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types and constants of the midpoint line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mlr_pkg;

    localparam int COORD_BITS  = 6;
    localparam int COLOR_BITS  = 24;
    localparam int DEPTH_BITS  = 32;
    localparam int DEC_BITS    = COORD_BITS + 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic [COLOR_BITS-1:0]      color_t;
    typedef logic [DEPTH_BITS-1:0]      depth_t;
    typedef logic signed [DEC_BITS-1:0] dec_t;

    typedef enum logic [1:0] {
        OCT_ENE = 2'd0,
        OCT_NNE = 2'd1,
        OCT_ESE = 2'd2,
        OCT_SSE = 2'd3
    } oct_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t stop;
        dec_t   decision;
        dec_t   inc_a;
        dec_t   inc_b;
        oct_t   octant;
        color_t color;
        depth_t depth;
    } cmd_t;

endpackage

`default_nettype wire

// ===== src/mlr_line_if.sv =====
// ----------------------------------------------------------------------------
// mlr_line_if
// Line channel: two endpoints, color and depth with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlr_line_if
    import mlr_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t line_color;
    depth_t line_depth;

    modport source (
        output valid, start_x, start_y, end_x, end_y, line_color, line_depth,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, end_x, end_y, line_color, line_depth,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/mlr_pixel_if.sv =====
// ----------------------------------------------------------------------------
// mlr_pixel_if
// Pixel channel: position, color, depth and last mark with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlr_pixel_if
    import mlr_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    depth_t pixel_depth;
    logic   last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, pixel_depth, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, pixel_depth, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/mlr_front.sv =====
// ----------------------------------------------------------------------------
// mlr_front
// Accepts a line, orders the endpoints left to right, picks the octant case
// and sets up the decision variable and its two increments.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_front
    import mlr_pkg::*;
(
    mlr_line_if.sink lines,
    input  logic     q_full,
    output logic     q_push,
    output cmd_t     q_cmd
);

    logic   swap;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    dec_t   dx;
    dec_t   dy;

    assign lines.ready = !q_full;
    assign q_push      = lines.valid && !q_full;

    always_comb
    begin
        swap = lines.start_x > lines.end_x;
        x1   = swap ? lines.end_x   : lines.start_x;
        y1   = swap ? lines.end_y   : lines.start_y;
        x2   = swap ? lines.start_x : lines.end_x;
        y2   = swap ? lines.start_y : lines.end_y;
        dx   = $signed({{(DEC_BITS-COORD_BITS){1'b0}}, x2})
             - $signed({{(DEC_BITS-COORD_BITS){1'b0}}, x1});
        dy   = $signed({{(DEC_BITS-COORD_BITS){1'b0}}, y2})
             - $signed({{(DEC_BITS-COORD_BITS){1'b0}}, y1});

        q_cmd.x     = x1;
        q_cmd.y     = y1;
        q_cmd.color = lines.line_color;
        q_cmd.depth = lines.line_depth;

        if (!dy[DEC_BITS-1])
        begin
            if (dy <= dx)
            begin
                q_cmd.octant   = OCT_ENE;
                q_cmd.stop     = x2;
                q_cmd.decision = dy + dy - dx;
                q_cmd.inc_a    = dy + dy;
                q_cmd.inc_b    = dy + dy - dx - dx;
            end
            else
            begin
                q_cmd.octant   = OCT_NNE;
                q_cmd.stop     = y2;
                q_cmd.decision = dy - dx - dx;
                q_cmd.inc_a    = -(dx + dx);
                q_cmd.inc_b    = dy + dy - dx - dx;
            end
        end
        else
        begin
            if (-dy <= dx)
            begin
                q_cmd.octant   = OCT_ESE;
                q_cmd.stop     = x2;
                q_cmd.decision = dx + dy + dy;
                q_cmd.inc_a    = dy + dy;
                q_cmd.inc_b    = dx + dx + dy + dy;
            end
            else
            begin
                q_cmd.octant   = OCT_SSE;
                q_cmd.stop     = y2;
                q_cmd.decision = dx + dx + dy;
                q_cmd.inc_a    = dx + dx;
                q_cmd.inc_b    = dx + dx + dy + dy;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/mlr_queue.sv =====
// ----------------------------------------------------------------------------
// mlr_queue
// Short queue of set-up lines between the front and the stepper.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_queue
    import mlr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output cmd_t pop_cmd
);

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full     = count_reg == QCNT_BITS'(QUEUE_DEPTH);
    assign nonempty = count_reg != '0;
    assign pop_cmd  = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== src/mlr_back.sv =====
// ----------------------------------------------------------------------------
// mlr_back
// Midpoint stepper: holds the current pixel in registers, shows it on the
// pixel channel and advances one step on each transfer before the last.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_back
    import mlr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  cmd_t         q_cmd,
    output logic         q_pop,
    mlr_pixel_if.source  pixels
);

    logic   busy_reg;
    logic   busy_next;
    coord_t cnt_reg;
    coord_t cnt_next;
    coord_t cur_x_reg;
    coord_t cur_x_next;
    coord_t cur_y_reg;
    coord_t cur_y_next;
    coord_t stop_reg;
    coord_t stop_next;
    dec_t   dec_reg;
    dec_t   dec_next;
    dec_t   inc_a_reg;
    dec_t   inc_a_next;
    dec_t   inc_b_reg;
    dec_t   inc_b_next;
    oct_t   oct_reg;
    oct_t   oct_next;
    color_t color_reg;
    color_t color_next;
    depth_t depth_reg;
    depth_t depth_next;
    logic   at_end;
    logic   last;
    logic   xfer;
    logic   load;

    always_comb
    begin
        unique case (oct_reg)
            OCT_NNE: at_end = cur_y_reg >= stop_reg;
            OCT_SSE: at_end = cur_y_reg <= stop_reg;
            default: at_end = cur_x_reg >= stop_reg;
        endcase
    end

    // a line never yields more pixels than the coordinate range holds
    assign last = at_end || (cnt_reg == '1);
    assign xfer = busy_reg && pixels.ready;
    assign load = q_valid && (!busy_reg || (xfer && last));
    assign q_pop = load;

    assign pixels.valid       = busy_reg;
    assign pixels.pixel_x     = cur_x_reg;
    assign pixels.pixel_y     = cur_y_reg;
    assign pixels.pixel_color = color_reg;
    assign pixels.pixel_depth = depth_reg;
    assign pixels.last_pixel  = last;

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        stop_next  = stop_reg;
        dec_next   = dec_reg;
        inc_a_next = inc_a_reg;
        inc_b_next = inc_b_reg;
        oct_next   = oct_reg;
        color_next = color_reg;
        depth_next = depth_reg;

        if (load)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            cur_x_next = q_cmd.x;
            cur_y_next = q_cmd.y;
            stop_next  = q_cmd.stop;
            dec_next   = q_cmd.decision;
            inc_a_next = q_cmd.inc_a;
            inc_b_next = q_cmd.inc_b;
            oct_next   = q_cmd.octant;
            color_next = q_cmd.color;
            depth_next = q_cmd.depth;
        end
        else if (xfer && last)
        begin
            busy_next = 1'b0;
        end
        else if (xfer)
        begin
            cnt_next = cnt_reg + 1'b1;
            unique case (oct_reg)
                OCT_ENE:
                begin
                    cur_x_next = cur_x_reg + 1'b1;
                    if (dec_reg < 0)
                    begin
                        dec_next = dec_reg + inc_a_reg;
                    end
                    else
                    begin
                        cur_y_next = cur_y_reg + 1'b1;
                        dec_next   = dec_reg + inc_b_reg;
                    end
                end
                OCT_NNE:
                begin
                    cur_y_next = cur_y_reg + 1'b1;
                    if (dec_reg > 0)
                    begin
                        dec_next = dec_reg + inc_a_reg;
                    end
                    else
                    begin
                        cur_x_next = cur_x_reg + 1'b1;
                        dec_next   = dec_reg + inc_b_reg;
                    end
                end
                OCT_ESE:
                begin
                    cur_x_next = cur_x_reg + 1'b1;
                    if (dec_reg > 0)
                    begin
                        dec_next = dec_reg + inc_a_reg;
                    end
                    else
                    begin
                        cur_y_next = cur_y_reg - 1'b1;
                        dec_next   = dec_reg + inc_b_reg;
                    end
                end
                OCT_SSE:
                begin
                    cur_y_next = cur_y_reg - 1'b1;
                    if (dec_reg < 0)
                    begin
                        dec_next = dec_reg + inc_a_reg;
                    end
                    else
                    begin
                        cur_x_next = cur_x_reg + 1'b1;
                        dec_next   = dec_reg + inc_b_reg;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            oct_reg  <= OCT_ENE;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            oct_reg  <= oct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        stop_reg  <= stop_next;
        dec_reg   <= dec_next;
        inc_a_reg <= inc_a_next;
        inc_b_reg <= inc_b_next;
        color_reg <= color_next;
        depth_reg <= depth_next;
    end

endmodule

`default_nettype wire

// ===== src/midpoint_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Midpoint line rasterizer: set-up front, two-entry queue, pixel stepper.
//
//   channel   dir   payload                                         width
//   lines     in    start_x, start_y, end_x, end_y, color, depth    80
//   pixels    out   pixel_x, pixel_y, color, depth, last_pixel      69
//
// A line of n pixels (1 to 64) leaves the stepper one pixel per cycle while
// the pixel side is ready; the next queued line starts right after the last pixel.
// Lines are set up in the cycle they transfer and queued two deep.
// Reset empties the queue and idles the stepper.
// A stall on the pixel side holds the current pixel; lines keep
// transferring until the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_line_rasterizer
    import mlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mlr_line_if.sink    lines,
    mlr_pixel_if.source pixels
);

    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    logic q_nonempty;
    cmd_t q_pop_cmd;

    mlr_front u_front (
        .lines  (lines),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_push_cmd)
    );

    mlr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .pop_cmd  (q_pop_cmd)
    );

    mlr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_nonempty),
        .q_cmd   (q_pop_cmd),
        .q_pop   (q_pop),
        .pixels  (pixels)
    );

endmodule

`default_nettype wire

// ===== tb/midpoint_line_rasterizer_tb.sv =====
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_tb
// Self-checking bench for the midpoint line rasterizer. Lines go in through
// a bursty sender and pixels come out against a receiver with its own stall
// pattern. A scoreboard steps its own midpoint decision variable for every
// accepted line and compares each pixel transfer field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mlr_pkg::*;

    localparam int MAX_PIXELS   = 1 << COORD_BITS;
    localparam int COORD_MAX    = MAX_PIXELS - 1;
    localparam int RANDOM_LINES = 370;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_LIMIT  = 50;

    typedef struct {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        color_t color;
        depth_t depth;
    } line_t;

    typedef struct {
        coord_t x;
        coord_t y;
        color_t color;
        depth_t depth;
        logic   last;
    } pixel_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BURSTY
    } stall_mode_t;

    class pixel_scoreboard;
        pixel_t pending_pixels[$];
        int     mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending_count();
            return pending_pixels.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // walk the line the way the stepper does and queue its pixels
        function void add_line(line_t l);
            coord_t x1, y1, x2, y2, cx, cy, stop, t;
            int     dx, dy, cnt;
            dec_t   dec, inc_a, inc_b;
            oct_t   oct;
            logic   done;
            pixel_t p;
            x1 = l.sx;
            y1 = l.sy;
            x2 = l.ex;
            y2 = l.ey;
            if (x1 > x2)
            begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            dx = int'(x2) - int'(x1);
            dy = int'(y2) - int'(y1);
            if (dy >= 0)
            begin
                if (dy <= dx)
                begin
                    oct   = OCT_ENE;
                    stop  = x2;
                    dec   = dec_t'(2 * dy - dx);
                    inc_a = dec_t'(2 * dy);
                    inc_b = dec_t'(2 * dy - 2 * dx);
                end
                else
                begin
                    oct   = OCT_NNE;
                    stop  = y2;
                    dec   = dec_t'(dy - 2 * dx);
                    inc_a = dec_t'(-2 * dx);
                    inc_b = dec_t'(2 * dy - 2 * dx);
                end
            end
            else
            begin
                if (-dy <= dx)
                begin
                    oct   = OCT_ESE;
                    stop  = x2;
                    dec   = dec_t'(dx + 2 * dy);
                    inc_a = dec_t'(2 * dy);
                    inc_b = dec_t'(2 * dx + 2 * dy);
                end
                else
                begin
                    oct   = OCT_SSE;
                    stop  = y2;
                    dec   = dec_t'(2 * dx + dy);
                    inc_a = dec_t'(2 * dx);
                    inc_b = dec_t'(2 * dx + 2 * dy);
                end
            end
            cx   = x1;
            cy   = y1;
            cnt  = 0;
            done = 1'b0;
            while (!done)
            begin
                case (oct)
                    OCT_NNE: done = (cy >= stop);
                    OCT_SSE: done = (cy <= stop);
                    default: done = (cx >= stop);
                endcase
                if (cnt == MAX_PIXELS - 1)
                    done = 1'b1;
                p.x     = cx;
                p.y     = cy;
                p.color = l.color;
                p.depth = l.depth;
                p.last  = done;
                pending_pixels.insert(pending_pixels.size(), p);
                cnt++;
                if (!done)
                begin
                    case (oct)
                        OCT_ENE:
                        begin
                            cx++;
                            if (dec < 0) dec = dec + inc_a;
                            else
                            begin
                                cy++;
                                dec = dec + inc_b;
                            end
                        end
                        OCT_NNE:
                        begin
                            cy++;
                            if (dec > 0) dec = dec + inc_a;
                            else
                            begin
                                cx++;
                                dec = dec + inc_b;
                            end
                        end
                        OCT_ESE:
                        begin
                            cx++;
                            if (dec > 0) dec = dec + inc_a;
                            else
                            begin
                                cy--;
                                dec = dec + inc_b;
                            end
                        end
                        default:
                        begin
                            cy--;
                            if (dec < 0) dec = dec + inc_a;
                            else
                            begin
                                cx++;
                                dec = dec + inc_b;
                            end
                        end
                    endcase
                end
            end
        endfunction

        task check_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                report_mismatch($sformatf("pixel (%0d,%0d) with no line pending",
                                          got.x, got.y));
                return;
            end
            want = pending_pixels.pop_front();
            if (got.x !== want.x)
                report_mismatch($sformatf("pixel_x got %0d want %0d", got.x, want.x));
            if (got.y !== want.y)
                report_mismatch($sformatf("pixel_y got %0d want %0d", got.y, want.y));
            if (got.color !== want.color)
                report_mismatch($sformatf("pixel_color got %06h want %06h",
                                          got.color, want.color));
            if (got.depth !== want.depth)
                report_mismatch($sformatf("pixel_depth got %08h want %08h",
                                          got.depth, want.depth));
            if (got.last !== want.last)
                report_mismatch($sformatf("last_pixel got %0b want %0b at (%0d,%0d)",
                                          got.last, want.last, want.x, want.y));
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   cycle_count = 0;
    int   burst_left  = 0;

    pixel_scoreboard sb = new();

    mlr_line_if  lines_if();
    mlr_pixel_if pixels_if();

    midpoint_line_rasterizer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .lines  (lines_if),
        .pixels (pixels_if)
    );

    always #2 clk = ~clk;

    function automatic line_t make_line(int sx, int sy, int ex, int ey,
                                        color_t color, depth_t depth);
        line_t l;
        l.sx    = coord_t'(sx);
        l.sy    = coord_t'(sy);
        l.ex    = coord_t'(ex);
        l.ey    = coord_t'(ey);
        l.color = color;
        l.depth = depth;
        return l;
    endfunction

    function automatic void append_line(ref line_t q[$], input line_t l);
        q.insert(q.size(), l);
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    // mostly short lines, some degenerate or diagonal ones, some anywhere on the grid
    function automatic line_t random_line();
        int sx, sy, ex, ey, kind, len;
        kind = $urandom_range(0, 9);
        sx   = $urandom_range(0, COORD_MAX);
        sy   = $urandom_range(0, COORD_MAX);
        ex   = $urandom_range(0, COORD_MAX);
        ey   = $urandom_range(0, COORD_MAX);
        len  = $urandom_range(0, 20) - 10;
        if (kind < 6)
        begin
            ex = clamp_coord(sx + $urandom_range(0, 16) - 8);
            ey = clamp_coord(sy + $urandom_range(0, 16) - 8);
        end
        else if (kind == 6)
        begin
            case ($urandom_range(0, 3))
                0: ex = sx;
                1: ey = sy;
                2: begin ex = sx; ey = sy; end
                default:
                begin
                    ex = clamp_coord(sx + len);
                    ey = ($urandom_range(0, 1) != 0) ? clamp_coord(sy + (ex - sx))
                                                     : clamp_coord(sy - (ex - sx));
                end
            endcase
        end
        return make_line(sx, sy, ex, ey, color_t'($urandom()), depth_t'($urandom()));
    endfunction

    // sender pacing: bursts of transfers separated by idle gaps
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                lines_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_line(line_t l);
        lines_if.valid      <= 1'b1;
        lines_if.start_x    <= l.sx;
        lines_if.start_y    <= l.sy;
        lines_if.end_x      <= l.ex;
        lines_if.end_y      <= l.ey;
        lines_if.line_color <= l.color;
        lines_if.line_depth <= l.depth;
        do @(negedge clk); while (!lines_if.ready);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        lines_if.valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // transfers are sampled mid-cycle, when every signal has settled
    always @(negedge clk)
    begin
        line_t  seen_line;
        pixel_t seen_pixel;
        if (rst_n)
        begin
            if (lines_if.valid && lines_if.ready)
            begin
                seen_line.sx    = lines_if.start_x;
                seen_line.sy    = lines_if.start_y;
                seen_line.ex    = lines_if.end_x;
                seen_line.ey    = lines_if.end_y;
                seen_line.color = lines_if.line_color;
                seen_line.depth = lines_if.line_depth;
                sb.add_line(seen_line);
            end
            if (pixels_if.valid && pixels_if.ready)
            begin
                seen_pixel.x     = pixels_if.pixel_x;
                seen_pixel.y     = pixels_if.pixel_y;
                seen_pixel.color = pixels_if.pixel_color;
                seen_pixel.depth = pixels_if.pixel_depth;
                seen_pixel.last  = pixels_if.last_pixel;
                sb.check_pixel(seen_pixel);
            end
        end
    end

    // receiver stall pattern
    initial
    begin
        stall_mode_t mode;
        int          span;
        int          run;
        logic        rdy;
        rdy = 1'b0;
        pixels_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(50, 400);
            while (span > 0)
            begin
                run = 1;
                case (mode)
                    STALL_NONE:  rdy = 1'b1;
                    STALL_LIGHT: rdy = ($urandom_range(0, 3) != 0);
                    STALL_HEAVY: rdy = ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        rdy = ~rdy;
                        run = $urandom_range(1, 8);
                    end
                endcase
                pixels_if.ready <= rdy;
                repeat (run) @(posedge clk);
                span -= run;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("midpoint_line_rasterizer test failed");
        $finish;
    end

    initial
    begin
        line_t directed[$];
        lines_if.valid      <= 1'b0;
        lines_if.start_x    <= '0;
        lines_if.start_y    <= '0;
        lines_if.end_x      <= '0;
        lines_if.end_y      <= '0;
        lines_if.line_color <= '0;
        lines_if.line_depth <= '0;

        // single points at both corners, extreme attributes
        append_line(directed, make_line(0, 0, 0, 0, 24'h000000, 32'h00000000));
        append_line(directed, make_line(63, 63, 63, 63, 24'hffffff, 32'hffffffff));
        // horizontal and both diagonals, each also given right to left
        append_line(directed, make_line(0, 0, 63, 0, 24'haaaaaa, 32'h55555555));
        append_line(directed, make_line(63, 0, 0, 0, 24'h555555, 32'haaaaaaaa));
        append_line(directed, make_line(0, 0, 63, 63, 24'h123456, 32'h89abcdef));
        append_line(directed, make_line(63, 63, 0, 0, 24'hfedcba, 32'h76543210));
        append_line(directed, make_line(0, 63, 63, 0, 24'h0f0f0f, 32'hf0f0f0f0));
        append_line(directed, make_line(63, 0, 0, 63, 24'hf0f0f0, 32'h0f0f0f0f));
        // vertical, equal x means no swap
        append_line(directed, make_line(5, 0, 5, 63, 24'h800000, 32'h80000000));
        append_line(directed, make_line(5, 63, 5, 0, 24'h000001, 32'h00000001));
        append_line(directed, make_line(63, 0, 63, 63, 24'hffffff, 32'h00000000));
        append_line(directed, make_line(0, 63, 0, 0, 24'h000000, 32'hffffffff));
        // steep both ways, with and without swap
        append_line(directed, make_line(0, 0, 20, 63, 24'h00ff00, 32'h0000ffff));
        append_line(directed, make_line(40, 63, 10, 0, 24'hff00ff, 32'hffff0000));
        append_line(directed, make_line(0, 63, 20, 0, 24'h00ffff, 32'h00ff00ff));
        append_line(directed, make_line(30, 0, 10, 50, 24'hff0000, 32'hff00ff00));
        // shallow both ways
        append_line(directed, make_line(0, 10, 63, 30, 24'h0000ff, 32'h12345678));
        append_line(directed, make_line(0, 50, 63, 20, 24'hffff00, 32'h87654321));
        append_line(directed, make_line(62, 40, 1, 45, 24'h3c3c3c, 32'hc3c3c3c3));
        // short lines around one step
        append_line(directed, make_line(0, 32, 1, 32, 24'h111111, 32'h22222222));
        append_line(directed, make_line(10, 10, 11, 12, 24'h333333, 32'h44444444));
        append_line(directed, make_line(10, 10, 12, 11, 24'h666666, 32'h77777777));
        append_line(directed, make_line(12, 11, 10, 10, 24'h999999, 32'hbbbbbbbb));
        append_line(directed, make_line(10, 12, 11, 10, 24'hcccccc, 32'hdddddddd));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            pace_sender();
            send_line(directed[i]);
        end
        wait_drained();

        for (int i = 0; i < RANDOM_LINES; i++)
        begin
            if (i != 0 && i % 100 == 0)
                wait_drained();
            pace_sender();
            send_line(random_line());
        end
        wait_drained();

        if (sb.mismatches == 0)
            $display("midpoint_line_rasterizer test passed");
        else
            $display("midpoint_line_rasterizer test failed");
        $finish;
    end

endmodule

`default_nettype wire
